[rtl/dvt_pkg.sv]
// Package for the divider and timer block with reload.
// Holds the request and response types, register codes and timer constants.
// No dependencies.
package dvt_pkg;

   // Request kinds carried in the low bits of the request user field.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // Register indexes.
   localparam logic [1:0] REG_DIV    = 2'd0;
   localparam logic [1:0] REG_COUNT  = 2'd1;
   localparam logic [1:0] REG_RELOAD = 2'd2;
   localparam logic [1:0] REG_CTRL   = 2'd3;

   localparam logic [15:0] DIV_RESET    = 16'hAB00;
   localparam logic [7:0]  CTRL_RESET   = 8'hF8;
   localparam logic [15:0] STROBE_POINT = 16'h2000;
   localparam logic [15:0] DIV_STEP     = 16'd4;
   localparam logic [10:0] PRESCALE_STEP = 11'd4;
   localparam logic [7:0]  COUNT_MAX    = 8'hFF;
   localparam int unsigned ENABLE_BIT   = 2;

   typedef struct packed {
      logic [7:0] write_data;
      logic [1:0] reg_index;
      logic [1:0] op;
   } req_item_type;

   typedef struct packed {
      logic       sequencer_strobe;
      logic       timer_irq;
      logic [7:0] read_data;
   } rsp_item_type;

   // Prescale period minus one for each clock select: 1024, 16, 64, 256 prescale counts.
   function automatic logic [10:0] period_mask(input logic [1:0] sel);
      logic [10:0] mask;
      case (sel)
         2'd0:    mask = 11'h3FF;
         2'd1:    mask = 11'h00F;
         2'd2:    mask = 11'h03F;
         default: mask = 11'h0FF;
      endcase
      return mask;
   endfunction

endpackage

[rtl/dvt_core.sv]
// Timer state and the single-pass update for one request.
// Depends on dvt_pkg for the request and response types and constants.
module dvt_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_fire,
   input  dvt_pkg::req_item_type item,
   output dvt_pkg::rsp_item_type result
);
   import dvt_pkg::*;

   logic [15:0] divider_ff, divider_in;
   logic [7:0]  counter_ff, counter_in;
   logic [7:0]  reload_ff, reload_in;
   logic [7:0]  control_ff, control_in;
   logic [10:0] prescale_ff, prescale_in;

   logic [15:0] div_next;
   logic [10:0] pre_sum;
   logic [10:0] mask;
   logic        period_hit;

   assign div_next   = divider_ff + DIV_STEP;
   assign pre_sum    = prescale_ff + PRESCALE_STEP;
   assign mask       = period_mask(control_ff[1:0]);
   // The period is a power of two, so reaching it means a bit above the mask is set.
   assign period_hit = (pre_sum & ~mask) != 11'd0;

   always_comb begin
      divider_in  = divider_ff;
      counter_in  = counter_ff;
      reload_in   = reload_ff;
      control_in  = control_ff;
      prescale_in = prescale_ff;
      result      = '0;
      unique case (item.op)
         OP_TICK: begin
            divider_in = div_next;
            result.sequencer_strobe = (div_next == STROBE_POINT);
            if (control_ff[ENABLE_BIT]) begin
               prescale_in = pre_sum;
               if (period_hit) begin
                  prescale_in = pre_sum & mask;
                  if (counter_ff == COUNT_MAX) begin
                     counter_in = reload_ff;
                     result.timer_irq = 1'b1;
                  end else begin
                     counter_in = counter_ff + 8'd1;
                  end
               end
            end
         end
         OP_READ: begin
            unique case (item.reg_index)
               REG_DIV:    result.read_data = divider_ff[15:8];
               REG_COUNT:  result.read_data = counter_ff;
               REG_RELOAD: result.read_data = reload_ff;
               default:    result.read_data = control_ff;
            endcase
         end
         OP_WRITE: begin
            unique case (item.reg_index)
               REG_DIV: begin
                  divider_in = '0;
                  counter_in = '0;
               end
               REG_COUNT:  counter_in = item.write_data;
               REG_RELOAD: reload_in  = item.write_data;
               default: begin
                  if (control_ff[1:0] != item.write_data[1:0]) begin
                     counter_in = '0;
                  end
                  control_in = item.write_data;
               end
            endcase
         end
         default: begin
            // The unused request kind changes nothing and answers with zeros.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff  <= DIV_RESET;
         counter_ff  <= '0;
         reload_ff   <= '0;
         control_ff  <= CTRL_RESET;
         prescale_ff <= '0;
      end else if (item_fire) begin
         divider_ff  <= divider_in;
         counter_ff  <= counter_in;
         reload_ff   <= reload_in;
         control_ff  <= control_in;
         prescale_ff <= prescale_in;
      end
   end

endmodule

[rtl/divider_timer_with_reload_core.sv]
// A request is held in the input register and its response in the result register, which
// is valid until rsp_tready takes it. Throughput: one request per cycle while rsp_tready
// does not stall; the timer state is updated in a single pass as a request leaves
// the input register, so the next request sees it at once.
// Reset: synchronous, active high; divider 0xAB00, control 0xF8, other timer state zero.
// Depends on dvt_pkg and dvt_core.
module divider_timer_with_reload_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] write_data
   input  logic [3:0]  req_tuser,  // [1:0] op, [3:2] reg_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // [7:0] read_data, [8] timer_irq,
                                   // [9] sequencer_strobe, [15:10] zero
);
   import dvt_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   logic         advance;
   logic         req_fire;

   // The input register moves on whenever the result register is empty or draining.
   assign advance     = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !s1_valid_ff || advance;
   assign req_fire    = req_tvalid && req_tready;
   assign s1_valid_in = req_fire || (s1_valid_ff && !advance);
   assign rsp_valid_in = (s1_valid_ff && advance) || (rsp_valid_ff && !rsp_tready);

   dvt_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (s1_valid_ff && advance),
      .item      (s1_item_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff.write_data <= req_tdata;
         s1_item_ff.reg_index  <= req_tuser[3:2];
         s1_item_ff.op         <= req_tuser[1:0];
      end
      if (s1_valid_ff && advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_item_ff};

   // Only ticks can raise the interrupt or the sequencer strobe.
   a_flags_on_tick_only: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && s1_item_ff.op != OP_TICK)
      |=> (rsp_item_ff.timer_irq == 1'b0 && rsp_item_ff.sequencer_strobe == 1'b0))
      else $error("timer flag raised on a non-tick request");

   // Writes return no read data.
   a_write_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && s1_item_ff.op == OP_WRITE)
      |=> (rsp_item_ff.read_data == 8'd0))
      else $error("write request returned nonzero read data");

   // A pending request in the input register reaches the result register whenever it is empty.
   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("request stuck in input register");

endmodule
